>>> sv/comment_strip_null_rewrite_top_macros.svh
// ----------------------------------------------------------------------------
// Comment strip / null rewrite: assertion macros
// Shared concurrent assertion forms. They are clocked on clock and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef COMMENT_STRIP_NULL_REWRITE_TOP_MACROS_SVH
`define COMMENT_STRIP_NULL_REWRITE_TOP_MACROS_SVH

// Same-cycle implication
`define CSNR_ASSERT_IMP(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) \
      else $error(msg);

// Next-cycle implication
`define CSNR_ASSERT_NXT(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) \
      else $error(msg);

`endif

>>> sv/csnr_pkg.sv
// ----------------------------------------------------------------------------
// Comment strip / null rewrite: package
// Item types, queue sizes and character codes shared by the block.
// ----------------------------------------------------------------------------
package csnr_pkg;

   // Input and output queue geometry
   localparam int unsigned IQ_DEPTH = 4;
   localparam int unsigned IQ_PTR_W = $clog2(IQ_DEPTH);
   localparam int unsigned IQ_CNT_W = $clog2(IQ_DEPTH + 1);
   localparam int unsigned OQ_DEPTH = 4;
   localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   // Decision window: four held bytes plus the incoming one
   localparam int unsigned WIN_DEPTH = 5;
   localparam int unsigned WIN_CNT_W = 3;

   // Builder call trailer
   localparam int unsigned BUILD_LEN   = 21;
   localparam int unsigned BUILD_IDX_W = 5;
   localparam logic [BUILD_IDX_W-1:0] BUILD_LAST_IDX = BUILD_IDX_W'(BUILD_LEN - 1);

   // Character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_I      = 8'h69;
   localparam logic [7:0] CH_L      = 8'h6C;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_U      = 8'h75;

   // One accepted input word, classified
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       present;   // data is a real character (nonzero)
   } item_type;

   // Head of the input queue as seen by the engine
   typedef struct packed {
      logic     avail;
      item_type item;
   } fq_head_type;

   // One result word
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } result_type;

   // Write side of the output queue
   typedef struct packed {
      logic       push;
      result_type word;
   } oq_write_type;

endpackage

>>> sv/csnr_front.sv
// ----------------------------------------------------------------------------
// Comment strip / null rewrite: front end
// Accepts input words, flags real characters and queues them for the engine.
// ----------------------------------------------------------------------------
module csnr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_in_last,
   output csnr_pkg::fq_head_type  head,
   input  logic                   take
);
   import csnr_pkg::*;

   item_type              mem_ff [IQ_DEPTH];
   logic [IQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [IQ_CNT_W-1:0]   count_ff, count_in;
   logic                  wr_en;
   logic                  rd_en;
   item_type              new_item;

   // classify incoming word
   always_comb begin
      new_item.data    = req_in_byte;
      new_item.last    = req_in_last;
      new_item.present = (req_in_byte != CH_NUL);
   end

   assign full  = (count_ff == IQ_CNT_W'(IQ_DEPTH));
   assign wr_en = push && !full;
   assign rd_en = take && (count_ff != '0);

   assign head.avail = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> sv/csnr_outq.sv
// ----------------------------------------------------------------------------
// Comment strip / null rewrite: output queue
// Holds rewritten words until the consumer pops them.
// ----------------------------------------------------------------------------
module csnr_outq (
   input  logic                   clock,
   input  logic                   reset,
   input  csnr_pkg::oq_write_type wr,
   output logic                   oq_full,
   output logic                   empty,
   input  logic                   pop,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_out_last
);
   import csnr_pkg::*;

   result_type            mem_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OQ_CNT_W-1:0]   count_ff, count_in;
   logic                  wr_en;
   logic                  rd_en;

   assign oq_full = (count_ff == OQ_CNT_W'(OQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign wr_en   = wr.push && !oq_full;
   assign rd_en   = pop && !empty;

   assign rsp_out_byte = mem_ff[rd_ptr_ff].data;
   assign rsp_out_last = mem_ff[rd_ptr_ff].last;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr.word;
      end
   end

endmodule

>>> sv/csnr_engine.sv
// ----------------------------------------------------------------------------
// Comment strip / null rewrite: engine
// Holds the lookahead window and lexer flags, decides one character position
// per step and emits the rewritten text, the end-of-text flush and trailer.
// ----------------------------------------------------------------------------
`include "comment_strip_null_rewrite_top_macros.svh"

module csnr_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_append_builder_call,
   input  csnr_pkg::fq_head_type  head,
   output logic                   take,
   input  logic                   oq_full,
   output csnr_pkg::oq_write_type wr
);
   import csnr_pkg::*;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_NIL_I,
      ST_NIL_L,
      ST_FLUSH,
      ST_BUILD,
      ST_END
   } state_type;

   // letters, digits and underscore
   function automatic logic is_word(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_UNDER);
   endfunction

   // trailer text: newline, then build(Project:new())
   function automatic logic [7:0] build_char(input logic [BUILD_IDX_W-1:0] idx);
      logic [7:0] c;
      unique case (idx)
         5'd0:    c = CH_NL;
         5'd1:    c = 8'h62; // b
         5'd2:    c = 8'h75; // u
         5'd3:    c = 8'h69; // i
         5'd4:    c = 8'h6C; // l
         5'd5:    c = 8'h64; // d
         5'd6:    c = 8'h28; // (
         5'd7:    c = 8'h50; // P
         5'd8:    c = 8'h72; // r
         5'd9:    c = 8'h6F; // o
         5'd10:   c = 8'h6A; // j
         5'd11:   c = 8'h65; // e
         5'd12:   c = 8'h63; // c
         5'd13:   c = 8'h74; // t
         5'd14:   c = 8'h3A; // :
         5'd15:   c = 8'h6E; // n
         5'd16:   c = 8'h65; // e
         5'd17:   c = 8'h77; // w
         5'd18:   c = 8'h28; // (
         5'd19:   c = 8'h29; // )
         5'd20:   c = 8'h29; // )
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

   // control state
   state_type               state_ff, state_in;
   logic                    flush_ff, flush_in;
   logic                    lc_ff, lc_in;
   logic                    bc_ff, bc_in;
   logic                    sq_ff, sq_in;
   logic                    dq_ff, dq_in;
   logic                    bs_odd_ff, bs_odd_in;
   logic [7:0]              prev_ff, prev_in;
   logic [WIN_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [BUILD_IDX_W-1:0]  bidx_ff, bidx_in;
   logic                    hold_v_ff, hold_v_in;
   logic                    append_ff;

   // payload
   logic [7:0]              buf_ff [WIN_DEPTH];
   logic [7:0]              buf_in [WIN_DEPTH];
   logic [7:0]              hold_ff, hold_in;

   // datapath
   logic                    go;
   logic                    add_byte;
   logic [7:0]              cmb [WIN_DEPTH];
   logic [WIN_CNT_W-1:0]    cmb_cnt;
   logic [7:0]              w [WIN_DEPTH];
   logic                    do_decide;
   logic                    sq1, dq1, lc1, bc1;
   logic [WIN_CNT_W-1:0]    k_dec;
   logic                    emit_c, emit_nil;
   logic                    bs_r;
   logic [7:0]              prev_r;
   logic [3:0]              j;
   logic [7:0]              nb [WIN_DEPTH];
   logic                    em_v;
   logic [7:0]              em_b;

   assign csr_ready = 1'b1;
   assign go        = !oq_full;
   assign take      = go && (state_ff == ST_RUN) && head.avail;
   assign add_byte  = take && head.item.present;

   // window with the incoming character appended
   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         cmb[i] = buf_ff[i];
         if (add_byte && (cnt_ff == WIN_CNT_W'(i))) begin
            cmb[i] = head.item.data;
         end
      end
      cmb_cnt = add_byte ? cnt_ff + 1'b1 : cnt_ff;
      // positions past the text read as end of text
      for (int i = 0; i < WIN_DEPTH; i++) begin
         w[i] = (WIN_CNT_W'(i) < cmb_cnt) ? cmb[i] : CH_NUL;
      end
   end

   assign do_decide = (take && !head.item.last && (cmb_cnt == WIN_CNT_W'(WIN_DEPTH))) ||
                      ((state_ff == ST_FLUSH) && go && (cnt_ff != '0));

   // decision for the front character
   always_comb begin
      sq1      = sq_ff ^ ((w[0] == CH_SQUOTE) && !lc_ff && !bc_ff && !dq_ff && !bs_odd_ff);
      dq1      = dq_ff ^ ((w[0] == CH_DQUOTE) && !lc_ff && !bc_ff && !sq1 && !bs_odd_ff);
      lc1      = lc_ff;
      bc1      = bc_ff;
      k_dec    = WIN_CNT_W'(1);
      emit_c   = 1'b0;
      emit_nil = 1'b0;
      priority if ((w[0] == CH_DASH) && (w[1] == CH_DASH) && !sq1 && !dq1) begin
         // comment opener: block if followed by two brackets
         if ((w[2] == CH_LBRACK) && (w[3] == CH_LBRACK)) begin
            bc1   = 1'b1;
            k_dec = WIN_CNT_W'(4);
         end else begin
            lc1   = 1'b1;
            k_dec = WIN_CNT_W'(2);
         end
      end else begin
         if (w[0] == CH_NL) begin
            lc1 = 1'b0;
         end
         priority if ((w[0] == CH_RBRACK) && (w[1] == CH_RBRACK) && bc_ff) begin
            bc1   = 1'b0;
            k_dec = WIN_CNT_W'(2);
         end else if (!lc1 && !bc_ff && !sq1 && !dq1 &&
                      (w[0] == CH_N) && (w[1] == CH_U) && (w[2] == CH_L) &&
                      (w[3] == CH_L) && !is_word(prev_ff) && !is_word(w[4])) begin
            emit_nil = 1'b1;
            k_dec    = WIN_CNT_W'(4);
         end else begin
            emit_c = !lc1 && !bc_ff;
         end
      end
   end

   // retire k characters: backslash parity, previous byte, shifted window
   always_comb begin
      bs_r   = bs_odd_ff;
      prev_r = prev_ff;
      for (int i = 0; i < 4; i++) begin
         if (WIN_CNT_W'(i) < k_dec) begin
            bs_r   = (w[i] == CH_BSLASH) ? !bs_r : 1'b0;
            prev_r = w[i];
         end
      end
      for (int i = 0; i < WIN_DEPTH; i++) begin
         j = 4'(i) + {1'b0, k_dec};
         nb[i] = (j < 4'(WIN_DEPTH)) ? cmb[j[2:0]] : cmb[i];
      end
   end

   // next state and emission
   always_comb begin
      state_in  = state_ff;
      flush_in  = flush_ff;
      lc_in     = lc_ff;
      bc_in     = bc_ff;
      sq_in     = sq_ff;
      dq_in     = dq_ff;
      bs_odd_in = bs_odd_ff;
      prev_in   = prev_ff;
      cnt_in    = cnt_ff;
      bidx_in   = bidx_ff;
      hold_v_in = hold_v_ff;
      hold_in   = hold_ff;
      buf_in    = buf_ff;
      em_v      = 1'b0;
      em_b      = w[0];
      wr.push   = 1'b0;
      wr.word   = '{data: hold_ff, last: 1'b0};

      if (go) begin
         unique case (state_ff)
            ST_RUN: begin
               if (take) begin
                  buf_in = cmb;
                  cnt_in = cmb_cnt;
                  if (head.item.last) begin
                     flush_in = 1'b1;
                     state_in = ST_FLUSH;
                  end
               end
            end
            ST_NIL_I: begin
               em_v     = 1'b1;
               em_b     = CH_I;
               state_in = ST_NIL_L;
            end
            ST_NIL_L: begin
               em_v     = 1'b1;
               em_b     = CH_L;
               state_in = flush_ff ? ST_FLUSH : ST_RUN;
            end
            ST_FLUSH: begin
               if (cnt_ff == '0) begin
                  state_in = append_ff ? ST_BUILD : ST_END;
               end
            end
            ST_BUILD: begin
               em_v    = 1'b1;
               em_b    = build_char(bidx_ff);
               bidx_in = bidx_ff + 1'b1;
               if (bidx_ff == BUILD_LAST_IDX) begin
                  bidx_in  = '0;
                  state_in = ST_END;
               end
            end
            ST_END: begin
               // close the stream: last word carries the end flag
               wr.push   = hold_v_ff;
               wr.word   = '{data: hold_ff, last: 1'b1};
               hold_v_in = 1'b0;
               flush_in  = 1'b0;
               lc_in     = 1'b0;
               bc_in     = 1'b0;
               sq_in     = 1'b0;
               dq_in     = 1'b0;
               bs_odd_in = 1'b0;
               prev_in   = CH_NUL;
               cnt_in    = '0;
               state_in  = ST_RUN;
            end
            default: begin
               state_in = ST_RUN;
            end
         endcase

         // one window decision
         if (do_decide) begin
            lc_in     = lc1;
            bc_in     = bc1;
            sq_in     = sq1;
            dq_in     = dq1;
            bs_odd_in = bs_r;
            prev_in   = prev_r;
            buf_in    = nb;
            cnt_in    = cmb_cnt - k_dec;
            em_v      = emit_c || emit_nil;
            em_b      = emit_nil ? CH_N : w[0];
            if (emit_nil) begin
               state_in = ST_NIL_I;
            end
         end

         // route emission: direct while streaming, through hold while flushing
         if (em_v) begin
            if (flush_ff) begin
               wr.push   = hold_v_ff;
               wr.word   = '{data: hold_ff, last: 1'b0};
               hold_in   = em_b;
               hold_v_in = 1'b1;
            end else begin
               wr.push = 1'b1;
               wr.word = '{data: em_b, last: 1'b0};
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_RUN;
         flush_ff  <= 1'b0;
         lc_ff     <= 1'b0;
         bc_ff     <= 1'b0;
         sq_ff     <= 1'b0;
         dq_ff     <= 1'b0;
         bs_odd_ff <= 1'b0;
         prev_ff   <= CH_NUL;
         cnt_ff    <= '0;
         bidx_ff   <= '0;
         hold_v_ff <= 1'b0;
         append_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         flush_ff  <= flush_in;
         lc_ff     <= lc_in;
         bc_ff     <= bc_in;
         sq_ff     <= sq_in;
         dq_ff     <= dq_in;
         bs_odd_ff <= bs_odd_in;
         prev_ff   <= prev_in;
         cnt_ff    <= cnt_in;
         bidx_ff   <= bidx_in;
         hold_v_ff <= hold_v_in;
         if (csr_valid) begin
            append_ff <= csr_append_builder_call;
         end
      end
   end

   // window and hold payload
   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      hold_ff <= hold_in;
   end

   `CSNR_ASSERT_IMP(a_push_room, wr.push, !oq_full, "engine wrote into a full output queue")
   `CSNR_ASSERT_IMP(a_run_window, state_ff == ST_RUN, cnt_ff <= 3'd4, "window overfull while streaming")
   `CSNR_ASSERT_IMP(a_hold_flush, hold_v_ff, flush_ff, "held word outside a flush")
   `CSNR_ASSERT_NXT(a_last_flush, take && head.item.last, state_ff == ST_FLUSH, "last word did not start flush")
   `CSNR_ASSERT_IMP(a_build_idx, state_ff == ST_BUILD, bidx_ff <= BUILD_LAST_IDX, "trailer index out of range")

endmodule

>>> sv/comment_strip_null_rewrite_top.sv
// ----------------------------------------------------------------------------
// Comment strip / null rewrite: top level
// Streams source text through comment removal and null-to-nil rewriting.
// ----------------------------------------------------------------------------
// Words enter on push/full and leave on empty/pop, both through four-deep
// queues. The engine decides one character position per cycle from a five-byte
// window while the output queue has room, so a steady stream moves one word
// per cycle; each null rewritten to nil holds the input while the three
// output characters are written one per cycle into the output queue. A word
// with the last flag starts a flush that decides the pending characters (at
// most five), then writes the 21-character builder call when it is enabled,
// then closes the stream. The configuration write channel is always ready
// and should only be used while no text is in flight.
module comment_strip_null_rewrite_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_append_builder_call
);
   import csnr_pkg::*;

   fq_head_type   head;
   logic          take;
   logic          oq_full;
   oq_write_type  wr;

   // input queue
   csnr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .head        (head),
      .take        (take)
   );

   // window, lexer state and rewriting
   csnr_engine u_engine (
      .clock                   (clock),
      .reset                   (reset),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_append_builder_call (csr_append_builder_call),
      .head                    (head),
      .take                    (take),
      .oq_full                 (oq_full),
      .wr                      (wr)
   );

   // result queue
   csnr_outq u_outq (
      .clock        (clock),
      .reset        (reset),
      .wr           (wr),
      .oq_full      (oq_full),
      .empty        (empty),
      .pop          (pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// Comment strip / null rewrite: testbench
// Streams short source texts through the block and predicts every output
// word from its own copy of the stripping and rewriting rules. A driver and a
// monitor with random idle bursts run the queue handshakes; every accepted
// output word is checked in order against the predicted stream.
// ----------------------------------------------------------------------------
module tb;
   import csnr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 60;
   localparam int MAX_REPORTS = 10;

   // One queued source word, or a hold point for the driver
   typedef struct {
      logic [7:0] ch;
      logic       last;
      bit         hold;
   } src_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       empty;
   logic       pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_append_builder_call = 1'b0;

   comment_strip_null_rewrite_top dut (
      .clock                   (clock),
      .reset                   (reset),
      .push                    (push),
      .full                    (full),
      .req_in_byte             (req_in_byte),
      .req_in_last             (req_in_last),
      .empty                   (empty),
      .pop                     (pop),
      .rsp_out_byte            (rsp_out_byte),
      .rsp_out_last            (rsp_out_last),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_append_builder_call (csr_append_builder_call)
   );

   always #5 clock = ~clock;

   src_word_type src_q[$];
   result_type   want_chars[$];
   result_type   step_chars[$];
   int           mismatches = 0;
   int           cycles = 0;
   bit           idle_on = 1'b1;
   int           idle_pct = 30;

   // Predictor state
   logic [7:0] win [0:4];
   int         win_fill = 0;
   bit         in_lc = 1'b0, in_bc = 1'b0, in_sq = 1'b0, in_dq = 1'b0;
   bit         bs_odd = 1'b0;
   logic [7:0] prev_ch = CH_NUL;
   bit         cfg_append = 1'b0;
   string      builder_txt = "\nbuild(Project:new())";

   function automatic bit word_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || c == CH_UNDER;
   endfunction

   function automatic logic [7:0] win_at(int k);
      return (k < win_fill) ? win[k] : CH_NUL;
   endfunction

   function automatic void put_char(logic [7:0] c);
      result_type r;
      r.data = c;
      r.last = 1'b0;
      step_chars.push_back(r);
   endfunction

   // Decide the front character; returns how many raw characters it uses
   function automatic int decide_front();
      logic [7:0] c, c1, c2, c3, c4;
      bit esc;
      c = win_at(0); c1 = win_at(1); c2 = win_at(2); c3 = win_at(3); c4 = win_at(4);
      esc = bs_odd;
      if (c == CH_SQUOTE && !in_lc && !in_bc && !in_dq && !esc) in_sq = !in_sq;
      if (c == CH_DQUOTE && !in_lc && !in_bc && !in_sq && !esc) in_dq = !in_dq;
      // comment openers count even inside another comment
      if (c == CH_DASH && c1 == CH_DASH && !in_sq && !in_dq) begin
         if (c2 == CH_LBRACK && c3 == CH_LBRACK) begin
            in_bc = 1'b1;
            return 4;
         end
         in_lc = 1'b1;
         return 2;
      end
      if (c == CH_NL && in_lc) in_lc = 1'b0;
      if (c == CH_RBRACK && c1 == CH_RBRACK && in_bc) begin
         in_bc = 1'b0;
         return 2;
      end
      // whole word null in plain code
      if (!in_lc && !in_bc && !in_sq && !in_dq &&
          c == CH_N && c1 == CH_U && c2 == CH_L && c3 == CH_L &&
          !word_char(prev_ch) && !word_char(c4)) begin
         put_char(CH_N);
         put_char(CH_I);
         put_char(CH_L);
         return 4;
      end
      if (!in_lc && !in_bc) put_char(c);
      return 1;
   endfunction

   // Drop k characters from the window, tracking the backslash run
   function automatic void retire_front(int k);
      int n;
      n = (k > win_fill) ? win_fill : k;
      for (int i = 0; i < n; i++) begin
         bs_odd  = (win[i] == CH_BSLASH) ? !bs_odd : 1'b0;
         prev_ch = win[i];
      end
      for (int i = 0; i < win_fill - n; i++) win[i] = win[i + n];
      win_fill = win_fill - n;
   endfunction

   function automatic void clear_stream();
      in_lc = 1'b0; in_bc = 1'b0; in_sq = 1'b0; in_dq = 1'b0;
      bs_odd = 1'b0;
      prev_ch = CH_NUL;
      win_fill = 0;
   endfunction

   // Expected output words for one accepted source word
   function automatic void predict_word(logic [7:0] ch, logic last);
      step_chars.delete();
      if (ch != CH_NUL) begin
         win[win_fill] = ch;
         win_fill++;
      end
      if (!last) begin
         if (win_fill == 5) retire_front(decide_front());
      end else begin
         while (win_fill > 0) retire_front(decide_front());
         if (cfg_append)
            for (int i = 0; i < builder_txt.len(); i++) put_char(builder_txt[i]);
         if (step_chars.size() > 0) step_chars[step_chars.size() - 1].last = 1'b1;
         clear_stream();
      end
      foreach (step_chars[i]) want_chars.push_back(step_chars[i]);
   endfunction

   // Driver: feeds src_q into the push side
   int           src_gap = 0;
   src_word_type drv_w;
   logic         drv_push;
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) predict_word(req_in_byte, req_in_last);
         if (!(push && full)) begin
            drv_push = 1'b0;
            if (src_gap > 0) begin
               src_gap--;
            end else if (src_q.size() > 0 && src_q[0].hold) begin
               // hold until the block has delivered all it owes
               if (want_chars.size() == 0) void'(src_q.pop_front());
            end else if (src_q.size() > 0) begin
               drv_w = src_q.pop_front();
               req_in_byte <= drv_w.ch;
               req_in_last <= drv_w.last;
               drv_push = 1'b1;
               if (idle_on && $urandom_range(0, 99) < idle_pct)
                  src_gap = $urandom_range(1, 6);
            end
            push <= drv_push;
         end
      end
   end

   // Monitor: pops results and checks them in order
   int         snk_gap = 0;
   result_type got_w;
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (want_chars.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected word: byte %02h last %0b", rsp_out_byte, rsp_out_last);
            end else begin
               got_w = want_chars.pop_front();
               if (rsp_out_byte !== got_w.data || rsp_out_last !== got_w.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                              got_w.data, got_w.last, rsp_out_byte, rsp_out_last);
               end
            end
         end
         if (snk_gap > 0) begin
            snk_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
            if (idle_on && $urandom_range(0, 99) < idle_pct)
               snk_gap = $urandom_range(1, 6);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic void add_word(logic [7:0] ch, logic last, bit hold);
      src_word_type w;
      w.ch = ch;
      w.last = last;
      w.hold = hold;
      src_q.push_back(w);
   endfunction

   function automatic void add_str(string s, bit end_text);
      for (int i = 0; i < s.len(); i++)
         add_word(s[i], end_text && (i == s.len() - 1), 1'b0);
   endfunction

   // One random text built from tokens; returns its word count
   function automatic int add_text(int ntok, bit with_hold);
      logic [7:0] txt[$];
      string      pool;
      int         r;
      pool = "nulabxyz_09AZ";
      for (int t = 0; t < ntok; t++) begin
         r = $urandom_range(0, 99);
         if (r < 14) begin
            txt.push_back(CH_N); txt.push_back(CH_U);
            txt.push_back(CH_L); txt.push_back(CH_L);
         end else if (r < 20) begin
            txt.push_back(CH_DASH); txt.push_back(CH_DASH);
         end else if (r < 25) begin
            txt.push_back(CH_DASH); txt.push_back(CH_DASH);
            txt.push_back(CH_LBRACK); txt.push_back(CH_LBRACK);
         end else if (r < 31) begin
            txt.push_back(CH_RBRACK); txt.push_back(CH_RBRACK);
         end else if (r < 38) begin
            txt.push_back(CH_SQUOTE);
         end else if (r < 45) begin
            txt.push_back(CH_DQUOTE);
         end else if (r < 52) begin
            repeat ($urandom_range(1, 3)) txt.push_back(CH_BSLASH);
         end else if (r < 60) begin
            txt.push_back(CH_NL);
         end else if (r < 66) begin
            txt.push_back(" ");
         end else if (r < 80) begin
            txt.push_back(pool[$urandom_range(0, pool.len() - 1)]);
         end else if (r < 95) begin
            txt.push_back(8'($urandom_range(1, 255)));
         end else begin
            txt.push_back(CH_NUL);
         end
      end
      // sometimes the last flag rides on a zero byte
      if (txt.size() == 0 || $urandom_range(0, 9) == 0) txt.push_back(CH_NUL);
      foreach (txt[i]) begin
         if (with_hold && i == txt.size() / 2) add_word(CH_NUL, 1'b0, 1'b1);
         add_word(txt[i], i == txt.size() - 1, 1'b0);
      end
      return txt.size();
   endfunction

   function automatic void add_random(int target, bit with_hold);
      int sent;
      bit held;
      sent = 0;
      held = 1'b0;
      while (sent < target) begin
         if (with_hold && !held && sent >= target / 2) begin
            sent += add_text($urandom_range(3, 8), 1'b1);
            held = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            sent += add_text($urandom_range(0, 2), 1'b0);
         end else begin
            sent += add_text($urandom_range(1, 8), 1'b0);
         end
      end
   endfunction

   task automatic write_cfg(bit v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_append_builder_call <= v;
      do @(posedge clock); while (!csr_ready);
      cfg_append = v;
      csr_valid <= 1'b0;
   endtask

   // Wait until everything sent has been delivered, then let the block settle
   task automatic drain();
      while (src_q.size() != 0 || push || want_chars.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed texts, builder call off
      idle_on = 1'b1;
      idle_pct = 30;
      add_str("null", 1'b1);
      add_str("--x\n", 1'b1);
      add_str("--[[a]]\"\\\"\"", 1'b1);
      add_word(CH_NUL, 1'b1, 1'b0);
      add_word(8'hFF, 1'b0, 1'b0);
      add_word(CH_NUL, 1'b0, 1'b0);
      add_word(8'h01, 1'b1, 1'b0);
      add_str("--", 1'b1);
      drain();

      // Random texts with the builder call, heavy idling and a hold point
      write_cfg(1'b1);
      idle_pct = 50;
      add_random(80, 1'b1);
      drain();

      // Random texts without the builder call, light idling
      write_cfg(1'b0);
      idle_pct = 15;
      add_random(80, 1'b0);
      drain();

      // Final stretch at full rate
      write_cfg(1'b1);
      idle_on = 1'b0;
      add_random(80, 1'b0);
      drain();

      if (mismatches == 0 && want_chars.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> comment_strip_null_rewrite_top.f
+incdir+sv
sv/csnr_pkg.sv
sv/csnr_front.sv
sv/csnr_outq.sv
sv/csnr_engine.sv
sv/comment_strip_null_rewrite_top.sv
dv/tb.sv
